### hdl/stok_pkg.sv
package stok_pkg;

	// result kinds
	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_EOI  = 2'd2;

	// scan modes; codes 5 to 7 behave as MODE_SKIP
	localparam logic [2:0] MODE_SKIP    = 3'd0;
	localparam logic [2:0] MODE_SLASH   = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_QUOTE   = 3'd3;
	localparam logic [2:0] MODE_WORD    = 3'd4;

	localparam int unsigned MAX_RES = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} res_t;

	// all results caused by one input byte
	typedef struct packed {
		logic [2:0]           cnt;
		res_t [MAX_RES-1:0]   slot;
	} bundle_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

### hdl/stok_front.sv
module stok_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  stok_pkg::qstat_t  qstat,
	output logic              push,
	output stok_pkg::bundle_t bundle
);
	import stok_pkg::*;

	logic [2:0] mode_q;
	logic [2:0] mode_nxt;
	logic       accept;

	function automatic logic is_single(input logic [7:0] c);
		return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
			c == CH_RPAREN || c == CH_SQUOTE || c == CH_COMMA;
	endfunction

	// classify the byte into up to four results and the next mode
	always_comb begin
		logic [2:0] n;
		logic       pend_slash;
		logic       word_like;
		n          = 3'd0;
		bundle     = '0;
		mode_nxt   = mode_q;
		pend_slash = (mode_q == MODE_SLASH) && (in_byte != CH_SLASH);
		word_like  = (mode_q == MODE_WORD) || pend_slash;
		priority if (mode_q == MODE_COMMENT) begin
			if (in_byte == CH_NUL) begin
				bundle.slot[n[1:0]] = '{KIND_EOI, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else if (in_byte == CH_NL) begin
				mode_nxt = MODE_SKIP;
			end
		end else if (mode_q == MODE_QUOTE) begin
			if (in_byte == CH_DQUOTE) begin
				bundle.slot[n[1:0]] = '{KIND_END, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else if (in_byte == CH_NUL) begin
				bundle.slot[n[1:0]] = '{KIND_END, 8'd0}; n = n + 3'd1;
				bundle.slot[n[1:0]] = '{KIND_EOI, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else begin
				bundle.slot[n[1:0]] = '{KIND_BYTE, in_byte}; n = n + 3'd1;
			end
		end else if (mode_q == MODE_SLASH && in_byte == CH_SLASH) begin
			mode_nxt = MODE_COMMENT;
		end else if (word_like) begin
			if (pend_slash) begin
				bundle.slot[n[1:0]] = '{KIND_BYTE, CH_SLASH}; n = n + 3'd1;
			end
			if (in_byte == CH_NUL) begin
				bundle.slot[n[1:0]] = '{KIND_END, 8'd0}; n = n + 3'd1;
				bundle.slot[n[1:0]] = '{KIND_EOI, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else if (in_byte <= CH_SPACE) begin
				bundle.slot[n[1:0]] = '{KIND_END, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else if (is_single(in_byte)) begin
				bundle.slot[n[1:0]] = '{KIND_END, 8'd0}; n = n + 3'd1;
				bundle.slot[n[1:0]] = '{KIND_BYTE, in_byte}; n = n + 3'd1;
				bundle.slot[n[1:0]] = '{KIND_END, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else begin
				bundle.slot[n[1:0]] = '{KIND_BYTE, in_byte}; n = n + 3'd1;
				mode_nxt = MODE_WORD;
			end
		end else begin
			if (in_byte == CH_NUL) begin
				bundle.slot[n[1:0]] = '{KIND_EOI, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else if (in_byte <= CH_SPACE) begin
				mode_nxt = MODE_SKIP;
			end else if (in_byte == CH_SLASH) begin
				mode_nxt = MODE_SLASH;
			end else if (in_byte == CH_DQUOTE) begin
				mode_nxt = MODE_QUOTE;
			end else if (is_single(in_byte)) begin
				bundle.slot[n[1:0]] = '{KIND_BYTE, in_byte}; n = n + 3'd1;
				bundle.slot[n[1:0]] = '{KIND_END, 8'd0}; n = n + 3'd1;
				mode_nxt = MODE_SKIP;
			end else begin
				bundle.slot[n[1:0]] = '{KIND_BYTE, in_byte}; n = n + 3'd1;
				mode_nxt = MODE_WORD;
			end
		end
		bundle.cnt = n;
	end

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	// bytes with no results never enter the queue
	assign push     = accept && (bundle.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
		end else if (accept) begin
			mode_q <= mode_nxt;
		end
	end

endmodule

### hdl/stok_queue.sv
module stok_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  stok_pkg::bundle_t wdata,
	input  logic              pop,
	output stok_pkg::bundle_t rdata,
	output stok_pkg::qstat_t  qstat
);
	import stok_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bundle_t        mem_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rdata       = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/stok_back.sv
module stok_back (
	input  logic              clk,
	input  logic              arst_n,
	input  stok_pkg::bundle_t head,
	input  stok_pkg::qstat_t  qstat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic [1:0]        kind,
	output logic              last
);
	import stok_pkg::*;

	logic [1:0] idx_q;
	logic       ov_q;
	res_t       res_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	assign load    = !qstat.empty && (!ov_q || out_ready);
	assign is_last = ({1'b0, idx_q} == head.cnt - 3'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.slot[idx_q];
			last_q <= is_last;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = res_q.data;
	assign kind      = res_q.kind;
	assign last      = last_q;

endmodule

### hdl/script_tokenizer_stream_top.sv
// A byte's bundle is queued when its transfer is taken; the back then loads its results.
// Throughput: one byte per cycle while the queue has room; one result per cycle leaves
//   the output register while out_ready is high, so a byte's results leave in turn and
//   QDEPTH queued bundles soak up the bursts (up to four results per byte).
// Reset: arst_n clears the scan mode to between-tokens, empties the queue and the output.
// No result ever appears for bytes that are skipped.
module script_tokenizer_stream_top #(
	parameter int unsigned QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last
);
	import stok_pkg::*;

	// front to queue
	bundle_t q_wdata;
	logic    q_push;
	// queue to back
	bundle_t q_head;
	logic    q_pop;
	qstat_t  q_stat;

	// Front: holds the scan mode, turns each byte into a bundle of results.
	// Ready only depends on queue space, never on the output side.
	stok_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.qstat    (q_stat),
		.push     (q_push),
		.bundle   (q_wdata)
	);

	// Short bundle queue decoupling the two sides.
	stok_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_head),
		.qstat  (q_stat)
	);

	// Back: while out_ready is high, walks the head bundle one result per cycle into
	// the output register, flagging the final one of each byte.
	stok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.qstat     (q_stat),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

`ifndef SYNTH
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_wdata.cnt != 3'd0 && q_wdata.cnt <= 3'd4 && !q_stat.full))
		else $error("bad bundle pushed");

	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_EOI) |-> last)
		else $error("end of input not last result");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_BYTE) |-> (out_byte == 8'd0))
		else $error("marker carries data");
`endif

endmodule

### verif/script_tokenizer_stream_top_tb.sv
module script_tokenizer_stream_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import stok_pkg::*;

	// share of cycles in which either side idles, in per cent
	localparam int unsigned IDLE_PCT      = 37;
	// far above the slowest correct run
	localparam int unsigned LIMIT_CYCLES  = 300_000;
	// quiet cycles after the last expected result, to catch stray output
	localparam int unsigned SETTLE_CYCLES = 20;
	// receiver hold-off used to fill the block up
	localparam int unsigned HOLD_CYCLES   = 150;

	// one expected result, fields as the block presents them
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       last;
	} tok_res_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;

	// results still owed by the block, oldest first
	tok_res_t    expected_tokens[$];
	// results of the byte being predicted
	tok_res_t    byte_results[$];
	// predictor's copy of the scan mode
	logic [2:0]  model_mode = MODE_SKIP;

	// no idling on either side while set
	bit          steady       = 1'b0;
	// hold-off request to the receiver, in cycles
	int unsigned hold_req     = 0;
	int unsigned hold_left    = 0;
	int unsigned bytes_sent   = 0;
	int unsigned results_seen = 0;
	int unsigned eoi_seen     = 0;
	int unsigned err_count    = 0;
	int unsigned cycle_count  = 0;

	script_tokenizer_stream_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: tracks the scan mode and works out the results of a byte
	// ------------------------------------------------------------------

	function automatic bit is_single_char(input logic [7:0] c);
		return c == CH_LBRACE || c == CH_RBRACE || c == CH_LPAREN ||
			c == CH_RPAREN || c == CH_SQUOTE || c == CH_COMMA;
	endfunction

	function automatic void put_result(input logic [1:0] k, input logic [7:0] c);
		tok_res_t r;
		r.data = (k == KIND_BYTE) ? c : 8'h00;
		r.kind = k;
		r.last = 1'b0;
		byte_results.push_back(r);
	endfunction

	// byte seen between tokens
	function automatic void skip_step(input logic [7:0] c);
		if (c == CH_NUL) begin
			put_result(KIND_EOI, 8'h00);
			model_mode = MODE_SKIP;
		end else if (c <= CH_SPACE) begin
			model_mode = MODE_SKIP;
		end else if (c == CH_SLASH) begin
			model_mode = MODE_SLASH;
		end else if (c == CH_DQUOTE) begin
			model_mode = MODE_QUOTE;
		end else if (is_single_char(c)) begin
			put_result(KIND_BYTE, c);
			put_result(KIND_END, 8'h00);
			model_mode = MODE_SKIP;
		end else begin
			put_result(KIND_BYTE, c);
			model_mode = MODE_WORD;
		end
	endfunction

	// byte seen inside a word
	function automatic void word_step(input logic [7:0] c);
		if (c == CH_NUL) begin
			put_result(KIND_END, 8'h00);
			put_result(KIND_EOI, 8'h00);
			model_mode = MODE_SKIP;
		end else if (c <= CH_SPACE) begin
			put_result(KIND_END, 8'h00);
			model_mode = MODE_SKIP;
		end else if (is_single_char(c)) begin
			// close the word, then the character is a token of its own
			put_result(KIND_END, 8'h00);
			skip_step(c);
		end else begin
			put_result(KIND_BYTE, c);
			model_mode = MODE_WORD;
		end
	endfunction

	function automatic void tokenize_byte(input logic [7:0] c);
		tok_res_t r;
		byte_results.delete();
		case (model_mode)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					model_mode = MODE_COMMENT;
				end else begin
					// held-back slash opens a word
					put_result(KIND_BYTE, CH_SLASH);
					word_step(c);
				end
			end
			MODE_COMMENT: begin
				if (c == CH_NUL) begin
					put_result(KIND_EOI, 8'h00);
					model_mode = MODE_SKIP;
				end else if (c == CH_NL) begin
					model_mode = MODE_SKIP;
				end
			end
			MODE_QUOTE: begin
				if (c == CH_DQUOTE) begin
					put_result(KIND_END, 8'h00);
					model_mode = MODE_SKIP;
				end else if (c == CH_NUL) begin
					put_result(KIND_END, 8'h00);
					put_result(KIND_EOI, 8'h00);
					model_mode = MODE_SKIP;
				end else begin
					put_result(KIND_BYTE, c);
				end
			end
			MODE_WORD: begin
				word_step(c);
			end
			default: begin
				skip_step(c);
			end
		endcase
		if (byte_results.size() != 0) begin
			r = byte_results.pop_back();
			r.last = 1'b1;
			byte_results.push_back(r);
		end
		foreach (byte_results[i])
			expected_tokens.push_back(byte_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Character pickers for generated text
	// ------------------------------------------------------------------

	// word byte; a first byte must not open a comment, a quote or a slash word
	function automatic logic [7:0] word_char(input bit first);
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 255));
		while (is_single_char(c) || (first && (c == CH_SLASH || c == CH_DQUOTE)));
		return c;
	endfunction

	// any non-zero byte but one
	function automatic logic [7:0] char_except(input logic [7:0] bar);
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == bar);
		return c;
	endfunction

	function automatic logic [7:0] single_char();
		case ($urandom_range(5))
			0:       return CH_LBRACE;
			1:       return CH_RBRACE;
			2:       return CH_LPAREN;
			3:       return CH_RPAREN;
			4:       return CH_SQUOTE;
			default: return CH_COMMA;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offers one byte and returns at the edge of its transfer. Called at a
	// rising edge; random idle cycles go first, with junk on in_byte.
	task automatic send_byte(input logic [7:0] c);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			in_byte  <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= c;
		do
			@(posedge clk);
		while (!in_ready);
		tokenize_byte(c);
		bytes_sent++;
	endtask

	// One text: a handful of tokens, optionally separated, closed by a zero.
	// Quotes and comments are sometimes left open so the zero closes them.
	task automatic send_random_text();
		int unsigned n_tok;
		int unsigned len;
		int unsigned pick;
		n_tok = $urandom_range(1, 8);
		repeat (n_tok) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				len = $urandom_range(1, 6);
				send_byte(word_char(1'b1));
				repeat (len - 1) send_byte(word_char(1'b0));
			end else if (pick < 50) begin
				send_byte(CH_DQUOTE);
				repeat ($urandom_range(0, 5)) send_byte(char_except(CH_DQUOTE));
				if ($urandom_range(9) != 0)
					send_byte(CH_DQUOTE);
			end else if (pick < 65) begin
				send_byte(single_char());
			end else if (pick < 75) begin
				send_byte(CH_SLASH);
				send_byte(CH_SLASH);
				repeat ($urandom_range(0, 4)) send_byte(char_except(CH_NL));
				if ($urandom_range(9) != 0)
					send_byte(CH_NL);
			end else if (pick < 85) begin
				// word opened by a slash, followed by whatever comes
				send_byte(CH_SLASH);
				case ($urandom_range(3))
					0:       send_byte(word_char(1'b0));
					1:       send_byte(CH_DQUOTE);
					2:       send_byte(single_char());
					default: send_byte(8'($urandom_range(1, 32)));
				endcase
				repeat ($urandom_range(0, 2)) send_byte(word_char(1'b0));
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 32)));
			end
			if ($urandom_range(1) != 0)
				send_byte(8'($urandom_range(1, 32)));
		end
		send_byte(CH_NUL);
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Ready with random idling; a hold-off request is counted down here.
	always @(posedge clk) begin : receiver
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Each output transfer against the oldest expected result.
	always @(posedge clk) begin : token_checker
		tok_res_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			results_seen++;
			if (kind == KIND_EOI)
				eoi_seen++;
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected result: byte %02h kind %0d last %0b",
					out_byte, kind, last));
			end else begin
				want = expected_tokens.pop_front();
				if (out_byte !== want.data)
					report_mismatch($sformatf("result %0d: byte %02h, want %02h",
						results_seen, out_byte, want.data));
				if (kind !== want.kind)
					report_mismatch($sformatf("result %0d: kind %0d, want %0d",
						results_seen, kind, want.kind));
				if (last !== want.last)
					report_mismatch($sformatf("result %0d: last %0b, want %0b",
						results_seen, last, want.last));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, expected_tokens.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Single-character tokens, one of them ending a word, and the byte
	// extremes inside a word closed by a space.
	task automatic test_single_chars();
		logic [7:0] s[$];
		s = {8'h61, CH_COMMA, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_SQUOTE,
			8'hff, 8'h21, CH_SPACE};
		foreach (s[i]) send_byte(s[i]);
	endtask

	// Pending slash: into a word before a single character (four results),
	// into a comment, into a word before a quote; zero ending a word and a
	// comment.
	task automatic test_slash_and_comments();
		logic [7:0] s[$];
		s = {CH_SLASH, CH_LPAREN,
			CH_SLASH, CH_SLASH, 8'hff, CH_NL,
			CH_SLASH, CH_DQUOTE, CH_NUL,
			CH_SLASH, CH_SLASH, CH_NUL};
		foreach (s[i]) send_byte(s[i]);
	endtask

	// Empty quotes, zero inside quotes, zero between tokens.
	task automatic test_quotes();
		logic [7:0] s[$];
		s = {CH_DQUOTE, CH_DQUOTE, CH_DQUOTE, 8'h01, CH_NUL, CH_NUL};
		foreach (s[i]) send_byte(s[i]);
	endtask

	task automatic test_random_text(input int unsigned n_bytes);
		int unsigned goal;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal)
			send_random_text();
	endtask

	// back-to-back transfers on both sides
	task automatic test_steady_stream(input int unsigned n_bytes);
		steady = 1'b1;
		test_random_text(n_bytes);
		steady = 1'b0;
	endtask

	// Receiver stops for a long stretch while bytes keep coming, so the
	// queue fills and in_ready drops.
	task automatic test_backpressure(input int unsigned n_bytes);
		hold_req = HOLD_CYCLES;
		steady   = 1'b1;
		test_random_text(n_bytes);
		steady   = 1'b0;
	endtask

	// unstructured bytes, then a zero to finish the text
	task automatic test_noise(input int unsigned n_bytes);
		repeat (n_bytes) send_byte(8'($urandom));
		send_byte(CH_NUL);
	endtask

	initial begin : run
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_chars();
		test_slash_and_comments();
		test_quotes();
		test_random_text(200);
		test_steady_stream(60);
		test_backpressure(40);
		test_noise(40);

		// last byte taken: stop offering, wait for what is owed, then settle
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d text bytes sent, %0d results checked, %0d of them end-of-input",
			bytes_sent, results_seen, eoi_seen);
		$display("receiver held off once for %0d cycles; %0d mismatches",
			HOLD_CYCLES, err_count);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
